[rtl/core/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared widths, codes and controller/datapath interface types of the
// binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int HEAP_DEPTH = 256;
   localparam int SYMBOL_W   = 8;
   localparam int WEIGHT_W   = 24;
   localparam int ENTRY_W    = SYMBOL_W + WEIGHT_W;
   localparam int STATUS_W   = 2;
   localparam int HELD_W     = 9;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic       cap_req;
      logic       ins_setup;
      logic       rd_parent;
      logic       up_step;
      logic       rd_root_last;
      logic       rm_setup;
      logic       rd_child;
      logic       dn_step;
      logic       wr_hole;
      logic       load_rsp;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic up_go;
      logic has_left;
      logic dn_go;
   } stat_type;

endpackage

[rtl/core/bmhq_dp.sv]
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap datapath: entry memory, entry count, hole position, moving entry,
// compare logic and result register.
// ----------------------------------------------------------------------------
module bmhq_dp #(
   parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bmhq_pkg::cmd_type              cmd,
   output bmhq_pkg::stat_type             stat,
   input  logic [bmhq_pkg::SYMBOL_W-1:0]  req_symbol_in,
   input  logic [bmhq_pkg::WEIGHT_W-1:0]  req_weight_in,
   output logic [bmhq_pkg::SYMBOL_W-1:0]  rsp_symbol_out,
   output logic [bmhq_pkg::WEIGHT_W-1:0]  rsp_weight_out,
   output logic [bmhq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bmhq_pkg::HELD_W-1:0]    rsp_entries_held
);

   localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int EW = bmhq_pkg::ENTRY_W;
   localparam int WW = bmhq_pkg::WEIGHT_W;
   localparam int SW = bmhq_pkg::SYMBOL_W;
   localparam int HW = bmhq_pkg::HELD_W;

   logic [EW-1:0] mem [HEAP_DEPTH];

   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [EW-1:0] mov_ff, mov_in;
   logic [EW-1:0] res_ff, res_in;
   logic [EW-1:0] rd_a_ff, rd_b_ff;

   logic [SW-1:0] rsp_symbol_ff;
   logic [WW-1:0] rsp_weight_ff;
   logic [bmhq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [HW-1:0] rsp_held_ff;

   logic [IW-1:0] pos_m1, parent, last_addr, child_idx;
   logic [IW+1:0] left_w, right_w, count_x;
   logic          has_left, has_right;
   logic [WW-1:0] wi, wl, wr;
   logic          dn_go;
   logic [EW-1:0] child_data;
   logic          rd_en, we;
   logic [IW-1:0] rd_addr_a, rd_addr_b, wr_addr;
   logic [EW-1:0] wr_data;

   assign pos_m1    = pos_ff - IW'(1);
   assign parent    = pos_m1 >> 1;
   assign last_addr = IW'(count_ff - CW'(1));

   assign left_w    = {1'b0, pos_ff, 1'b1};
   assign right_w   = left_w + (IW+2)'(1);
   assign count_x   = (IW+2)'(count_ff);
   assign has_left  = left_w < count_x;
   assign has_right = right_w < count_x;

   assign wi = mov_ff[WW-1:0];
   assign wl = rd_a_ff[WW-1:0];
   assign wr = rd_b_ff[WW-1:0];

   always_comb begin
      if (has_right) begin
         dn_go = !((wi < wl) && (wi < wr));
         if (wl < wr) begin
            child_idx  = IW'(left_w);
            child_data = rd_a_ff;
         end else begin
            child_idx  = IW'(right_w);
            child_data = rd_b_ff;
         end
      end else begin
         dn_go      = !(wi < wl);
         child_idx  = IW'(left_w);
         child_data = rd_a_ff;
      end
   end

   assign stat.full     = count_ff >= CW'(HEAP_DEPTH);
   assign stat.empty    = count_ff == '0;
   assign stat.at_root  = pos_ff == '0;
   assign stat.up_go    = wi < wl;
   assign stat.has_left = has_left;
   assign stat.dn_go    = dn_go;

   always_comb begin
      rd_en     = cmd.rd_parent | cmd.rd_root_last | cmd.rd_child;
      rd_addr_a = IW'(left_w);
      rd_addr_b = has_right ? IW'(right_w) : IW'(left_w);
      if (cmd.rd_parent) begin
         rd_addr_a = parent;
      end else if (cmd.rd_root_last) begin
         rd_addr_a = '0;
         rd_addr_b = last_addr;
      end
   end

   always_comb begin
      we      = cmd.up_step | cmd.dn_step | cmd.wr_hole;
      wr_addr = pos_ff;
      if (cmd.up_step) begin
         wr_data = rd_a_ff;
      end else if (cmd.dn_step) begin
         wr_data = child_data;
      end else begin
         wr_data = mov_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      mov_in   = mov_ff;
      res_in   = res_ff;
      if (cmd.cap_req) begin
         mov_in = {req_symbol_in, req_weight_in};
         res_in = '0;
      end
      if (cmd.ins_setup) begin
         pos_in   = IW'(count_ff);
         count_in = count_ff + CW'(1);
      end
      if (cmd.up_step) begin
         pos_in = parent;
      end
      if (cmd.rm_setup) begin
         mov_in   = rd_b_ff;
         res_in   = rd_a_ff;
         count_in = count_ff - CW'(1);
         pos_in   = '0;
      end
      if (cmd.dn_step) begin
         pos_in = child_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff <= pos_in;
      mov_ff <= mov_in;
      res_ff <= res_in;
      if (cmd.load_rsp) begin
         rsp_symbol_ff <= res_ff[EW-1:WW];
         rsp_weight_ff <= res_ff[WW-1:0];
         rsp_status_ff <= cmd.code;
         rsp_held_ff   <= HW'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rsp_symbol_out   = rsp_symbol_ff;
   assign rsp_weight_out   = rsp_weight_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entries_held = rsp_held_ff;

endmodule

[rtl/core/bmhq_ctrl.sv]
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Heap controller: sequences insert sift-up, remove sift-down and the
// result handoff.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  bmhq_pkg::stat_type stat,
   output bmhq_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_RM_SETUP,
      ST_DN_CHK,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   bmhq_pkg::status_type code_ff, code_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.code = code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.cap_req = 1'b1;
               code_in     = bmhq_pkg::STATUS_OK;
               if (req_op == bmhq_pkg::OP_INSERT) begin
                  if (stat.full) begin
                     code_in  = bmhq_pkg::STATUS_FULL;
                     state_in = ST_DONE;
                  end else begin
                     cmd.ins_setup = 1'b1;
                     state_in      = ST_UP_CHK;
                  end
               end else begin
                  if (stat.empty) begin
                     code_in  = bmhq_pkg::STATUS_EMPTY;
                     state_in = ST_DONE;
                  end else begin
                     cmd.rd_root_last = 1'b1;
                     state_in         = ST_RM_SETUP;
                  end
               end
            end
         end
         ST_UP_CHK: begin
            if (stat.at_root) begin
               cmd.wr_hole = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (stat.up_go) begin
               cmd.up_step = 1'b1;
               state_in    = ST_UP_CHK;
            end else begin
               cmd.wr_hole = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_RM_SETUP: begin
            cmd.rm_setup = 1'b1;
            state_in     = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (stat.has_left) begin
               cmd.rd_child = 1'b1;
               state_in     = ST_DN_CMP;
            end else begin
               cmd.wr_hole = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_DN_CMP: begin
            if (stat.dn_go) begin
               cmd.dn_step = 1'b1;
               state_in    = ST_DN_CHK;
            end else begin
               cmd.wr_hole = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         code_ff      <= bmhq_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/binary_min_heap_queue.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue of (symbol, weight) entries held as a binary min-heap in
// a single memory.
// ----------------------------------------------------------------------------
// One transaction at a time: insert (op 0) or remove (op 1). The moving entry
// travels at most log2(HEAP_DEPTH) heap levels (eight for 256 entries). Each
// level costs one registered memory read (parent, or both children on the
// dual read port) and one compare-and-write step. An insert that climbs all
// the way to the root and a remove that sinks all the way to a leaf skip the
// last read and compare. A refused insert (full) or remove (empty) goes
// straight to the result and leaves the heap unchanged. Ties on sift-down go
// to the right child. A finished result sits in the output register while
// the next transaction is accepted.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
   parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [bmhq_pkg::SYMBOL_W-1:0]  req_symbol_in,
   input  logic [bmhq_pkg::WEIGHT_W-1:0]  req_weight_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bmhq_pkg::SYMBOL_W-1:0]  rsp_symbol_out,
   output logic [bmhq_pkg::WEIGHT_W-1:0]  rsp_weight_out,
   output logic [bmhq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bmhq_pkg::HELD_W-1:0]    rsp_entries_held
);

   bmhq_pkg::cmd_type  cmd;
   bmhq_pkg::stat_type stat;

   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bmhq_dp #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_symbol_in    (req_symbol_in),
      .req_weight_in    (req_weight_in),
      .rsp_symbol_out   (rsp_symbol_out),
      .rsp_weight_out   (rsp_weight_out),
      .rsp_status       (rsp_status),
      .rsp_entries_held (rsp_entries_held)
   );

endmodule

[verif/binary_min_heap_queue_tb.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_queue_tb
// Self-checking testbench for the binary min-heap priority queue. A
// behavioral heap model predicts every result. A monitor compares each
// accepted result field by field against the oldest prediction. Directed
// corner cases come first: empty remove, extreme weights and ties between
// children. Random traffic follows, biased to fill the heap past full, mix
// inserts and removes, and drain it past empty. The request channel sees
// random gaps and the response channel random stalls.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_tb;

   localparam int CYCLE_LIMIT = 800000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [bmhq_pkg::SYMBOL_W-1:0] symbol;
      logic [bmhq_pkg::WEIGHT_W-1:0] weight;
      bmhq_pkg::status_type          status;
      logic [bmhq_pkg::HELD_W-1:0]   held;
   } heap_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_op = bmhq_pkg::OP_INSERT;
   logic [bmhq_pkg::SYMBOL_W-1:0] req_symbol_in = '0;
   logic [bmhq_pkg::WEIGHT_W-1:0] req_weight_in = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [bmhq_pkg::SYMBOL_W-1:0] rsp_symbol_out;
   logic [bmhq_pkg::WEIGHT_W-1:0] rsp_weight_out;
   logic [bmhq_pkg::STATUS_W-1:0] rsp_status;
   logic [bmhq_pkg::HELD_W-1:0]   rsp_entries_held;

   logic [bmhq_pkg::ENTRY_W-1:0]  model_heap [bmhq_pkg::HEAP_DEPTH];
   int                            model_count = 0;
   heap_result_type               pending_results [$];
   int                            mismatch_count = 0;
   int                            cycle_count = 0;
   int                            stall_run = 0;
   bit                            quiet = 1'b0;

   binary_min_heap_queue dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_symbol_in    (req_symbol_in),
      .req_weight_in    (req_weight_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol_out   (rsp_symbol_out),
      .rsp_weight_out   (rsp_weight_out),
      .rsp_status       (rsp_status),
      .rsp_entries_held (rsp_entries_held)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void log_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endfunction

   function automatic void model_insert(logic [bmhq_pkg::SYMBOL_W-1:0] sym,
                                        logic [bmhq_pkg::WEIGHT_W-1:0] wgt);
      heap_result_type              res;
      int                           k;
      int                           parent;
      logic [bmhq_pkg::ENTRY_W-1:0] hold;
      res.symbol = '0;
      res.weight = '0;
      if (model_count >= bmhq_pkg::HEAP_DEPTH) begin
         res.status = bmhq_pkg::STATUS_FULL;
      end else begin
         res.status = bmhq_pkg::STATUS_OK;
         model_heap[model_count] = {sym, wgt};
         k = model_count;
         model_count++;
         while (k > 0) begin
            parent = (k - 1) / 2;
            if (model_heap[k][bmhq_pkg::WEIGHT_W-1:0] <
                model_heap[parent][bmhq_pkg::WEIGHT_W-1:0]) begin
               hold = model_heap[k];
               model_heap[k] = model_heap[parent];
               model_heap[parent] = hold;
               k = parent;
            end else begin
               break;
            end
         end
      end
      res.held = bmhq_pkg::HELD_W'(model_count);
      pending_results.push_back(res);
   endfunction

   function automatic void model_remove();
      heap_result_type               res;
      int                            i;
      int                            left;
      int                            right;
      int                            child;
      logic [bmhq_pkg::WEIGHT_W-1:0] wi;
      logic [bmhq_pkg::WEIGHT_W-1:0] wl;
      logic [bmhq_pkg::WEIGHT_W-1:0] wr;
      logic [bmhq_pkg::ENTRY_W-1:0]  hold;
      res.symbol = '0;
      res.weight = '0;
      if (model_count == 0) begin
         res.status = bmhq_pkg::STATUS_EMPTY;
      end else begin
         res.status = bmhq_pkg::STATUS_OK;
         res.symbol = model_heap[0][bmhq_pkg::ENTRY_W-1:bmhq_pkg::WEIGHT_W];
         res.weight = model_heap[0][bmhq_pkg::WEIGHT_W-1:0];
         model_heap[0] = model_heap[model_count-1];
         model_count--;
         i = 0;
         while (i < model_count) begin
            left = 2 * i + 1;
            right = left + 1;
            if (left >= model_count) break;
            wi = model_heap[i][bmhq_pkg::WEIGHT_W-1:0];
            wl = model_heap[left][bmhq_pkg::WEIGHT_W-1:0];
            if (right < model_count) begin
               wr = model_heap[right][bmhq_pkg::WEIGHT_W-1:0];
               if (wi < wl && wi < wr) break;
               child = (wl < wr) ? left : right;
            end else begin
               if (wi < wl) break;
               child = left;
            end
            hold = model_heap[i];
            model_heap[i] = model_heap[child];
            model_heap[child] = hold;
            i = child;
         end
      end
      res.held = bmhq_pkg::HELD_W'(model_count);
      pending_results.push_back(res);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [bmhq_pkg::WEIGHT_W-1:0] pick_weight();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return bmhq_pkg::WEIGHT_W'($urandom_range(0, 15));
      if (r < 35) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return {{(bmhq_pkg::WEIGHT_W-1){1'b1}}, 1'b0};
            default: return bmhq_pkg::WEIGHT_W'(1);
         endcase
      end
      return bmhq_pkg::WEIGHT_W'($urandom);
   endfunction

   task automatic send_op(input logic op, input logic [bmhq_pkg::SYMBOL_W-1:0] sym,
                          input logic [bmhq_pkg::WEIGHT_W-1:0] wgt);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_symbol_in <= sym;
      req_weight_in <= wgt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == bmhq_pkg::OP_INSERT) model_insert(sym, wgt);
      else model_remove();
   endtask

   task automatic run_random(input int count, input int insert_pct);
      int  n;
      logic op;
      for (n = 0; n < count; n++) begin
         if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
         op = ($urandom_range(0, 99) < insert_pct) ? bmhq_pkg::OP_INSERT
                                                    : bmhq_pkg::OP_REMOVE;
         send_op(op, bmhq_pkg::SYMBOL_W'($urandom), pick_weight());
      end
      quiet = 1'b0;
   endtask

   task automatic test_directed_corners();
      int n;
      send_op(bmhq_pkg::OP_REMOVE, 8'h00, 24'h000000);
      send_op(bmhq_pkg::OP_INSERT, 8'hFF, 24'hFFFFFF);
      send_op(bmhq_pkg::OP_INSERT, 8'h00, 24'h000000);
      send_op(bmhq_pkg::OP_INSERT, 8'hA5, 24'h800000);
      send_op(bmhq_pkg::OP_INSERT, 8'h5A, 24'h7FFFFF);
      // equal weights so sift-down has to break ties between children
      for (n = 1; n <= 6; n++) begin
         send_op(bmhq_pkg::OP_INSERT, bmhq_pkg::SYMBOL_W'(n), 24'h000007);
      end
      for (n = 0; n < 11; n++) send_op(bmhq_pkg::OP_REMOVE, 8'hFF, 24'hFFFFFF);
      send_op(bmhq_pkg::OP_REMOVE, 8'h3C, 24'h123456);
   endtask

   task automatic test_fill_past_full();
      run_random(340, 92);
   endtask

   task automatic test_mixed_traffic();
      run_random(260, 50);
   endtask

   task automatic test_drain_past_empty();
      run_random(340, 8);
   endtask

   task automatic test_churn();
      run_random(80, 85);
      run_random(80, 40);
   endtask

   always @(posedge clock) begin
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
         rsp_stall <= 1'b1;
         stall_run <= ($urandom_range(0, 99) < 10) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      heap_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            log_failure($sformatf("unexpected result: sym %h wgt %h status %0d held %0d",
                                  rsp_symbol_out, rsp_weight_out, rsp_status,
                                  rsp_entries_held));
         end else begin
            want = pending_results.pop_front();
            if (rsp_symbol_out !== want.symbol || rsp_weight_out !== want.weight ||
                rsp_status !== want.status || rsp_entries_held !== want.held) begin
               log_failure($sformatf({"result differs: expected sym %h wgt %h status %0d ",
                                      "held %0d, actual sym %h wgt %h status %0d held %0d"},
                                     want.symbol, want.weight, want.status, want.held,
                                     rsp_symbol_out, rsp_weight_out, rsp_status,
                                     rsp_entries_held));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("binary_min_heap_queue: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_fill_past_full();
      test_mixed_traffic();
      test_drain_past_empty();
      test_churn();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("binary_min_heap_queue: match");
      end else begin
         $display("binary_min_heap_queue: mismatch");
      end
      $finish;
   end

endmodule
